// ===== src/dwo_pkg.sv =====
// ----------------------------------------------------------------------------
// dwo_pkg
// Shared types, constants and tables of the wheel odometry block.
// ----------------------------------------------------------------------------
`default_nettype none
package dwo_pkg;

    localparam int CordicStepsDefault = 24;
    localparam int CordicStepsMax     = 32;
    localparam logic [31:0] UnitsPerRad = 32'd683565276;
    localparam logic signed [33:0] CordicGain = 34'sd652032874;

    localparam logic [1:0] CFG_WHEEL_DIAMETER = 2'd0;
    localparam logic [1:0] CFG_TRACK_WIDTH    = 2'd1;
    localparam logic [1:0] CFG_TICK_PERIOD    = 2'd2;

    localparam logic ACT_INTEGRATE = 1'b0;
    localparam logic ACT_ZERO      = 1'b1;

    typedef struct packed {
        logic               action;
        logic signed [15:0] left_wheel_rate;
        logic signed [15:0] right_wheel_rate;
    } dwo_in_t;

    typedef struct packed {
        logic signed [31:0] x_position;
        logic signed [31:0] y_position;
        logic        [31:0] heading;
        logic signed [31:0] speed;
        logic signed [31:0] turn_rate;
    } dwo_out_t;

    typedef struct packed {
        logic [1:0]  index;
        logic [31:0] data;
    } dwo_cfg_t;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] r;
        unique case (i)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10680862;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            5'd24: r = 32'd41;
            5'd25: r = 32'd20;
            5'd26: r = 32'd10;
            5'd27: r = 32'd5;
            5'd28: r = 32'd3;
            5'd29: r = 32'd1;
            5'd30: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/dwo_divider.sv =====
// ----------------------------------------------------------------------------
// dwo_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module dwo_divider import dwo_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [47:0] dividend,
    input  wire logic [16:0] divisor,
    output logic             done,
    output logic [47:0]      quotient
);
    logic [47:0] quo_reg;
    logic [16:0] rem_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [17:0] trial;

    assign trial    = {rem_reg, quo_reg[47]};
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                quo_reg  <= dividend;
                rem_reg  <= '0;
                cnt_reg  <= 6'd47;
            end else if (busy_reg) begin
                if (trial >= {1'b0, divisor}) begin
                    rem_reg <= 17'(trial - {1'b0, divisor});
                    quo_reg <= {quo_reg[46:0], 1'b1};
                end else begin
                    rem_reg <= trial[16:0];
                    quo_reg <= {quo_reg[46:0], 1'b0};
                end
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 6'd1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== src/differential_wheel_odometry.sv =====
// ----------------------------------------------------------------------------
// differential_wheel_odometry
// Differential-drive odometry: heading and x/y integration per tick.
// ----------------------------------------------------------------------------
// Usage:
//  - s_ channel: one tick transfer (action, left/right wheel rate, Q7.8).
//    action 1 clears heading and position and returns an all-zero result.
//  - m_ channel: one result transfer per tick (x, y, heading, speed, rate).
//  - cfg channel: register writes (diameter, track width, tick period),
//    taken only while idle; out-of-range indexes are dropped.
// Processing: an integrate tick passes from accept to result valid through
//   the bit-serial divider for the yaw rate, the CORDIC iterations on one
//   add/shift datapath, and three multiplies per axis on one multiplier.
//   With zero track width the divider is skipped. A zero tick goes
//   straight from idle to the output state. One tick in flight at a time,
//   so a new tick is taken only after the last result is transferred.
// Reset: aresetn clears heading/position and loads the register defaults.
// Stall: the result is held in an output register until m_ready; s_ready
//   stays low until the result is transferred.
// ----------------------------------------------------------------------------
`default_nettype none
module differential_wheel_odometry import dwo_pkg::*; #(
    parameter int CORDIC_STEPS = CordicStepsDefault
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire dwo_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output dwo_out_t      m_data,
    input  wire logic     cfg_valid,
    output logic          cfg_ready,
    input  wire dwo_cfg_t cfg_data
);
    localparam logic [4:0] LastStep = 5'(CORDIC_STEPS - 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_PREP, ST_DIV_WAIT, ST_RATE, ST_HMUL_LO, ST_HMUL_HI,
        ST_HEAD, ST_CORDIC, ST_MUL_C, ST_MUL_T, ST_MUL_TH, ST_ADD, ST_OUT
    } state_t;

    state_t state_reg;
    logic [15:0] diam_reg, track_reg;
    logic [23:0] tick_reg;
    logic [31:0] heading_reg, x_reg, y_reg;
    logic signed [31:0] speed_reg, rate_reg;
    logic signed [16:0] vsum_reg;
    logic signed [64:0] prod_reg;      // shared multiplier result
    logic [63:0] mag_reg;              // |rate * tick|
    logic [63:0] hi_reg;
    logic        neg_reg;
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [32:0] cz_reg;
    logic [4:0]  step_reg;
    logic        flip_reg;
    logic        axis_reg;             // 0: x, 1: y
    logic signed [47:0] dxy_reg;
    dwo_out_t out_reg;
    logic out_valid_reg;

    // divider
    logic div_start, div_done;
    logic [47:0] div_quo;
    logic signed [47:0] num_s;
    logic [47:0] num_abs;
    assign num_s   = 48'(vsum_reg * $signed({1'b0, diam_reg})) <<< 8;
    assign num_abs = num_s[47] ? 48'(-num_s) : num_s;
    assign div_start = (state_reg == ST_PREP) && (track_reg != '0);

    dwo_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(num_abs), .divisor({track_reg, 1'b0}),
        .done(div_done), .quotient(div_quo)
    );

    // shared multiplier operands
    logic signed [33:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [33:0] cs_sel;
    assign cs_sel = axis_reg ? (flip_reg ? -cy_reg : cy_reg)
                             : (flip_reg ? -cx_reg : cx_reg);
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_RATE:    begin mul_a = 34'(rate_reg); mul_b = 34'($signed({1'b0, tick_reg})); end
            ST_HMUL_LO: begin mul_a = $signed({2'b0, mag_reg[31:0]});
                              mul_b = $signed({2'b0, UnitsPerRad}); end
            ST_HMUL_HI: begin mul_a = $signed({2'b0, mag_reg[63:32]});
                              mul_b = $signed({2'b0, UnitsPerRad}); end
            ST_MUL_C:   begin mul_a = 34'(speed_reg); mul_b = cs_sel; end
            // dxy times tick in two halves: low 16 bits unsigned, then the
            // signed upper part weighted by 2^16
            ST_MUL_T:   begin mul_a = $signed({18'd0, dxy_reg[15:0]});
                              mul_b = 34'($signed({1'b0, tick_reg})); end
            ST_MUL_TH:  begin mul_a = 34'($signed(dxy_reg[47:16]));
                              mul_b = 34'($signed({1'b0, tick_reg})); end
            default: ;
        endcase
    end
    logic signed [67:0] mul_p;
    assign mul_p = mul_a * mul_b;

    // combinational values
    logic signed [17:0] vdiff;
    logic signed [34:0] spd_full;
    logic signed [31:0] speed_next;
    assign vdiff    = 18'(s_data.left_wheel_rate) - 18'(s_data.right_wheel_rate);
    assign spd_full = 35'(vdiff * $signed({1'b0, diam_reg})) >>> 10;
    assign speed_next = (spd_full > 35'sd2147483647) ? 32'sh7fffffff :
                        (spd_full < -35'sd2147483648) ? 32'sh80000000 : 32'(spd_full);

    logic signed [48:0] rate_full;
    logic signed [31:0] rate_sat;
    assign rate_full = num_s[47] ? 49'(div_quo) : -49'(div_quo);
    assign rate_sat  = (rate_full > 49'sd2147483647) ? 32'sh7fffffff :
                       (rate_full < -49'sd2147483648) ? 32'sh80000000 : 32'(rate_full);

    logic [63:0] units;
    logic [31:0] delta, head_new, a_fold;
    assign units = (hi_reg >> 8) + ((({56'd0, hi_reg[7:0]} << 32) + prod_reg[63:0]) >> 40);
    assign delta = neg_reg ? 32'(-units[31:0]) : units[31:0];
    assign head_new = heading_reg + delta;
    assign a_fold = ((head_new > 32'h40000000) && (head_new < 32'hC0000000))
                    ? head_new + 32'h80000000 : head_new;

    logic [31:0] at;
    logic signed [33:0] sx, sy;
    assign at = atan_entry(step_reg);
    assign sx = cx_reg >>> step_reg;
    assign sy = cy_reg >>> step_reg;

    logic signed [32:0] pos_cur;
    logic signed [32:0] pos_sum;
    logic signed [31:0] pos_sat;
    logic signed [29:0] dstep;
    assign dstep   = 30'(prod_reg >>> 38);
    assign pos_cur = axis_reg ? 33'($signed(y_reg)) : 33'($signed(x_reg));
    assign pos_sum = pos_cur + 33'(dstep);
    assign pos_sat = (pos_sum > 33'sd2147483647) ? 32'sh7fffffff :
                     (pos_sum < -33'sd2147483648) ? 32'sh80000000 : 32'(pos_sum);

    assign s_ready   = (state_reg == ST_IDLE) && !out_valid_reg;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            diam_reg      <= 16'd6554;
            track_reg     <= 16'd19661;
            tick_reg      <= 24'd167772;
            heading_reg   <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
        end else begin
            if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_data.index)
                    CFG_WHEEL_DIAMETER: diam_reg  <= cfg_data.data[15:0];
                    CFG_TRACK_WIDTH:    track_reg <= cfg_data.data[15:0];
                    CFG_TICK_PERIOD:    tick_reg  <= cfg_data.data[23:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE: if (s_valid && s_ready) begin
                    if (s_data.action == ACT_ZERO) begin
                        heading_reg <= '0; x_reg <= '0; y_reg <= '0;
                        out_reg <= '0;
                        state_reg <= ST_OUT;
                    end else begin
                        vsum_reg  <= 17'(s_data.left_wheel_rate) + 17'(s_data.right_wheel_rate);
                        speed_reg <= speed_next;
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    if (track_reg == '0) begin
                        // saturate against the sign of the full numerator
                        rate_reg <= (num_s > 48'sd0) ? 32'sh80000000 :
                                    (num_s < 48'sd0) ? 32'sh7fffffff : 32'sd0;
                        state_reg <= ST_RATE;
                    end else begin
                        state_reg <= ST_DIV_WAIT;
                    end
                end
                ST_DIV_WAIT: if (div_done) begin
                    rate_reg  <= rate_sat;
                    state_reg <= ST_RATE;
                end
                ST_RATE: begin
                    neg_reg   <= mul_p[67];
                    mag_reg   <= mul_p[67] ? 64'(-mul_p) : 64'(mul_p);
                    state_reg <= ST_HMUL_LO;
                end
                ST_HMUL_LO: begin
                    prod_reg  <= 65'(mul_p);
                    state_reg <= ST_HMUL_HI;
                end
                ST_HMUL_HI: begin
                    hi_reg    <= 64'(mul_p);
                    state_reg <= ST_HEAD;
                end
                ST_HEAD: begin
                    heading_reg <= head_new;
                    flip_reg    <= (head_new > 32'h40000000) && (head_new < 32'hC0000000);
                    cz_reg      <= 33'($signed(a_fold));
                    cx_reg      <= CordicGain;
                    cy_reg      <= '0;
                    step_reg    <= '0;
                    state_reg   <= ST_CORDIC;
                end
                ST_CORDIC: begin
                    if (!cz_reg[32]) begin
                        cx_reg <= cx_reg - sy;
                        cy_reg <= cy_reg + sx;
                        cz_reg <= cz_reg - 33'(at);
                    end else begin
                        cx_reg <= cx_reg + sy;
                        cy_reg <= cy_reg - sx;
                        cz_reg <= cz_reg + 33'(at);
                    end
                    if (step_reg == LastStep) begin
                        axis_reg  <= 1'b0;
                        state_reg <= ST_MUL_C;
                    end else begin
                        step_reg <= step_reg + 5'd1;
                    end
                end
                ST_MUL_C: begin
                    dxy_reg   <= 48'(mul_p >>> 16);
                    state_reg <= ST_MUL_T;
                end
                ST_MUL_T: begin
                    prod_reg  <= 65'(mul_p);
                    state_reg <= ST_MUL_TH;
                end
                ST_MUL_TH: begin
                    prod_reg  <= prod_reg + 65'(mul_p <<< 16);
                    state_reg <= ST_ADD;
                end
                ST_ADD: begin
                    if (axis_reg) begin
                        y_reg     <= pos_sat;
                        out_reg.x_position <= x_reg;
                        out_reg.y_position <= pos_sat;
                        out_reg.heading    <= heading_reg;
                        out_reg.speed      <= speed_reg;
                        out_reg.turn_rate  <= rate_reg;
                        state_reg <= ST_OUT;
                    end else begin
                        x_reg     <= pos_sat;
                        axis_reg  <= 1'b1;
                        state_reg <= ST_MUL_C;
                    end
                end
                ST_OUT: begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // result valid only rises out of the final state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result raised outside output state");
    // no new tick while a result is pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !s_ready)
        else $error("input ready with result pending");
    // cordic counter in range
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CORDIC |-> step_reg <= LastStep)
        else $error("cordic step overrun");
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the wheel odometry block: directed and random ticks
// under random idling, with register changes between phases, each result
// checked against a bit-exact predictor of rate, speed, heading and x/y.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top import dwo_pkg::*; ();

    localparam int MaxCycles = 3000000;
    localparam int SettleCycles = 200;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    dwo_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    dwo_out_t m_data;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    dwo_cfg_t cfg_data = '0;

    differential_wheel_odometry DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor state: registers and integrators
    logic [15:0] diam_q, track_q;
    logic [23:0] tick_q;
    logic [31:0] head_q, xpos_q, ypos_q;

    dwo_in_t  tick_queue[$];    // ticks waiting for the driver
    dwo_out_t pose_queue[$];    // predicted results, oldest first

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  send_hold = 1'b0;
    int  mismatches = 0;
    int  cycles = 0;

    function automatic longint floor_shift(longint v, int sh);
        return v >>> sh;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // CORDIC rotation from gain; angles past a quarter turn are folded by a
    // half turn and the result negated.
    task automatic rotate_heading(input logic [31:0] ang, output longint c,
                                  output longint s);
        longint z, x, y, nx;
        logic [31:0] a;
        bit flip;
        a = ang;
        flip = 1'b0;
        x = CordicGain;
        y = 0;
        if (a > 32'h4000_0000 && a < 32'hC000_0000) begin
            a = a + 32'h8000_0000;
            flip = 1'b1;
        end
        z = longint'($signed(a));
        for (int i = 0; i < CordicStepsDefault; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - longint'(atan_entry(5'(i)));
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + longint'(atan_entry(5'(i)));
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic predict_pose(input dwo_in_t t);
        dwo_out_t r;
        longint vl, vr, num, rate, spd, prod, c, s, dx, dy;
        logic [63:0] m, hi, lo, units;
        logic [31:0] delta;
        if (t.action == ACT_ZERO) begin
            head_q = '0;
            xpos_q = '0;
            ypos_q = '0;
            pose_queue.push_back('0);
            return;
        end
        vl = t.left_wheel_rate;
        vr = t.right_wheel_rate;
        num = (vl + vr) * longint'(diam_q) * 256;
        if (track_q == 0)
            rate = num > 0 ? -64'sd2147483648 : (num < 0 ? 64'sd2147483647 : 0);
        else
            rate = clamp32(-(num / (2 * longint'(track_q))));
        spd = clamp32(floor_shift((vl - vr) * longint'(diam_q), 10));
        // heading step on the magnitude, split to keep 64-bit products exact
        prod = rate * longint'(tick_q);
        m = prod < 0 ? 64'(-prod) : 64'(prod);
        hi = (m >> 32) * UnitsPerRad;
        lo = (m & 64'hFFFF_FFFF) * UnitsPerRad;
        units = (hi >> 8) + ((((hi & 64'hFF) << 32) + lo) >> 40);
        delta = units[31:0];
        if (prod < 0) delta = 32'd0 - delta;
        head_q = head_q + delta;
        rotate_heading(head_q, c, s);
        dx = floor_shift(floor_shift(spd * c, 16) * longint'(tick_q), 38);
        dy = floor_shift(floor_shift(spd * s, 16) * longint'(tick_q), 38);
        xpos_q = 32'(clamp32(longint'($signed(xpos_q)) + dx));
        ypos_q = 32'(clamp32(longint'($signed(ypos_q)) + dy));
        r.x_position = xpos_q;
        r.y_position = ypos_q;
        r.heading = head_q;
        r.speed = 32'(spd);
        r.turn_rate = 32'(rate);
        pose_queue.push_back(r);
    endtask

    // Driver: pulls the next tick on each transfer; valid holds until taken
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_ready) begin
                if (s_valid) predict_pose(s_data);
                if (tick_queue.size() > 0 && !send_hold &&
                    $urandom_range(99) >= send_idle_pct) begin
                    s_data <= tick_queue.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transfer with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn) begin
            cycles <= cycles + 1;
            if (m_valid && m_ready) begin
                if (pose_queue.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected result %h", m_data);
                end else begin
                    dwo_out_t e;
                    e = pose_queue.pop_front();
                    if (e.x_position !== m_data.x_position ||
                        e.y_position !== m_data.y_position ||
                        e.heading !== m_data.heading ||
                        e.speed !== m_data.speed ||
                        e.turn_rate !== m_data.turn_rate) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch x %0d/%0d y %0d/%0d hd %h/%h sp %0d/%0d tr %0d/%0d",
                                e.x_position, m_data.x_position,
                                e.y_position, m_data.y_position,
                                e.heading, m_data.heading, e.speed, m_data.speed,
                                e.turn_rate, m_data.turn_rate);
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (cycles > MaxCycles) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic dwo_in_t make_tick(logic act, logic [15:0] l, logic [15:0] r);
        dwo_in_t t;
        t.action = act;
        t.left_wheel_rate = l;
        t.right_wheel_rate = r;
        return t;
    endfunction

    // Forward motion has opposite wheel signs; mix in turns and extremes.
    function automatic dwo_in_t random_tick();
        logic [15:0] l, r;
        int k;
        k = $urandom_range(99);
        l = 16'($urandom);
        if (k < 55) r = -l + 16'($urandom_range(64)) - 16'd32;
        else if (k < 65) r = l;
        else r = 16'($urandom);
        if ($urandom_range(9) == 0) l = $urandom_range(1) ? 16'h7FFF : 16'h8000;
        return make_tick($urandom_range(49) == 0 ? ACT_ZERO : ACT_INTEGRATE, l, r);
    endfunction

    task automatic wait_drained();
        while (tick_queue.size() > 0 || s_valid || pose_queue.size() > 0)
            @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    // one write, with valid dropped before the next
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_data <= '{index: idx, data: val};
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_WHEEL_DIAMETER) diam_q = val[15:0];
        else if (idx == CFG_TRACK_WIDTH) track_q = val[15:0];
        else if (idx == CFG_TICK_PERIOD) tick_q = val[23:0];
        @(posedge aclk);
    endtask

    task automatic load_settings(input logic [31:0] d, input logic [31:0] w,
                                 input logic [31:0] p);
        wait_drained();
        write_reg(CFG_WHEEL_DIAMETER, d);
        write_reg(CFG_TRACK_WIDTH, w);
        write_reg(CFG_TICK_PERIOD, p);
    endtask

    task automatic random_phase(input int n);
        repeat (n) tick_queue.push_back(random_tick());
    endtask

    initial begin
        diam_q = 16'd6554;
        track_q = 16'd19661;
        tick_q = 24'd167772;
        head_q = '0;
        xpos_q = '0;
        ypos_q = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes, straight drive, spin, clear, idle tick
        send_idle_pct = 16;
        recv_idle_pct = 58;
        tick_queue.push_back(make_tick(ACT_INTEGRATE, 16'd0, 16'd0));
        tick_queue.push_back(make_tick(ACT_INTEGRATE, 16'h7FFF, 16'h8000));
        tick_queue.push_back(make_tick(ACT_INTEGRATE, 16'h8000, 16'h7FFF));
        tick_queue.push_back(make_tick(ACT_INTEGRATE, 16'h7FFF, 16'h7FFF));
        tick_queue.push_back(make_tick(ACT_INTEGRATE, 16'h8000, 16'h8000));
        tick_queue.push_back(make_tick(ACT_INTEGRATE, 16'hFFFF, 16'h0001));
        tick_queue.push_back(make_tick(ACT_INTEGRATE, 16'h0100, 16'hFF00));
        tick_queue.push_back(make_tick(ACT_ZERO, 16'hFFFF, 16'hFFFF));
        tick_queue.push_back(make_tick(ACT_INTEGRATE, 16'h5555, 16'hAAAA));
        tick_queue.push_back(make_tick(ACT_ZERO, 16'h0000, 16'h0000));

        // Invalid index is dropped; extreme geometry and period
        load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        write_reg(2'd3, 32'h0000_1234);
        repeat (6) tick_queue.push_back(make_tick(ACT_INTEGRATE, 16'h7FFF, 16'h7FFF));
        tick_queue.push_back(make_tick(ACT_INTEGRATE, 16'h8000, 16'h7FFF));
        load_settings(32'd65535, 32'd0, 32'd16777215);   // zero track width
        tick_queue.push_back(make_tick(ACT_INTEGRATE, 16'h1000, 16'h2000));
        tick_queue.push_back(make_tick(ACT_INTEGRATE, 16'hE000, 16'hF000));
        tick_queue.push_back(make_tick(ACT_INTEGRATE, 16'h1000, 16'hF000));
        load_settings(32'd0, 32'd1, 32'd0);              // no motion
        tick_queue.push_back(make_tick(ACT_INTEGRATE, 16'h7FFF, 16'h8000));
        tick_queue.push_back(make_tick(ACT_INTEGRATE, 16'h1234, 16'h4321));

        // Random phases under different settings and idling mixes
        load_settings(32'd6554, 32'd19661, 32'd167772);
        random_phase(400);
        wait_drained();
        send_hold = 1'b1;                                // sender pause
        repeat (30) @(posedge aclk);
        send_hold = 1'b0;
        load_settings(32'd1, 32'd65535, 32'd1);
        random_phase(200);
        send_idle_pct = 58;
        recv_idle_pct = 16;
        load_settings(32'd65535, 32'd1, 32'd16777215);
        random_phase(200);
        load_settings($urandom_range(65535), $urandom_range(65535),
                      $urandom_range(24'hFFFFFF));
        random_phase(400);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_settings(32'd30000, 32'd20000, 32'd4000000);
        random_phase(700);
        wait_drained();

        if (mismatches == 0 && pose_queue.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
